/* src/joint_pd_torque_mapper_macros.svh */
// Assertion macros for the joint PD torque mapper.
// Included by the top level; no other dependencies.
`ifndef JOINT_PD_TORQUE_MAPPER_MACROS_SVH
`define JOINT_PD_TORQUE_MAPPER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define JPTM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// Check that a condition never holds outside reset.
`define JPTM_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

/* src/jptm_pkg.sv */
// Shared types, constants and the microcode program of the joint PD torque mapper.
// No dependencies; used by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package jptm_pkg;

  localparam int JOINTS   = 4;
  localparam int IDX_W    = $clog2(JOINTS);
  localparam int POS_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int ERR_W    = POS_W + 1;
  localparam int IPER_W   = 32;
  localparam int VEL_SHIFT = 16;
  localparam int VEL_W    = 33;
  localparam int FORCE_SHIFT = 6;
  localparam int FORCE_W  = 45;
  localparam int FORCE_LO_W = 23;
  localparam int MUL_A_W  = ERR_W;
  localparam int MUL_B_W  = 34;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 64;
  localparam int TORQ_SHIFT = 12;
  localparam int TORQ_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int PC_W     = 4;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(JOINTS - 1);

  localparam logic [CFG_DATA_W-1:0] KP_RESET   = 64'h2800_1400_5000_5000;
  localparam logic [CFG_DATA_W-1:0] KV_RESET   = 64'h0066_0066_0066_0066;
  localparam logic [IPER_W-1:0]     IPER_RESET = 32'h03E8_0000;

  localparam logic signed [ACC_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [ACC_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KV   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IPER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COL1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COL2 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_COL3 = 3'd6;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DIP,
    MUL_KPE,
    MUL_KVV,
    MUL_CFH,
    MUL_CFL
  } mul_op_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_VEL,
    WR_FORCE,
    WR_TORQUE,
    WR_OUT
  } wr_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_JLOOP,
    JMP_ILOOP,
    JMP_END
  } jmp_e;

  typedef struct packed {
    mul_op_e         mul;
    acc_op_e         acc;
    wr_op_e          wr;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic             run;
    mul_op_e          mul;
    acc_op_e          acc;
    wr_op_e           wr;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] i;
  } ctl_t;

  localparam uword_t UWORD_NOP = '{
    mul: MUL_NONE, acc: ACC_HOLD, wr: WR_NONE, jmp: JMP_NEXT, target: '0
  };

  localparam logic [PC_W-1:0] PC_VEL   = 4'd0;
  localparam logic [PC_W-1:0] PC_KP    = 4'd1;
  localparam logic [PC_W-1:0] PC_KV    = 4'd2;
  localparam logic [PC_W-1:0] PC_FORCE = 4'd3;
  localparam logic [PC_W-1:0] PC_MCLR  = 4'd4;
  localparam logic [PC_W-1:0] PC_MHI   = 4'd5;
  localparam logic [PC_W-1:0] PC_MLO   = 4'd6;
  localparam logic [PC_W-1:0] PC_MTAIL = 4'd7;
  localparam logic [PC_W-1:0] PC_MOUT  = 4'd8;
  localparam logic [PC_W-1:0] PC_DONE  = 4'd9;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = UWORD_NOP;
    case (pc)
      PC_VEL: begin
        w.mul = MUL_DIP;
      end
      PC_KP: begin
        w.mul = MUL_KPE;
        w.wr  = WR_VEL;
      end
      PC_KV: begin
        w.mul = MUL_KVV;
        w.acc = ACC_LOAD;
      end
      PC_FORCE: begin
        w.wr     = WR_FORCE;
        w.jmp    = JMP_JLOOP;
        w.target = PC_VEL;
      end
      PC_MCLR: begin
        w.acc = ACC_CLR;
      end
      PC_MHI: begin
        w.mul = MUL_CFH;
        w.acc = ACC_ADD;
      end
      PC_MLO: begin
        w.mul    = MUL_CFL;
        w.acc    = ACC_ADD_HI;
        w.jmp    = JMP_JLOOP;
        w.target = PC_MHI;
      end
      PC_MTAIL: begin
        w.acc = ACC_ADD;
      end
      PC_MOUT: begin
        w.acc    = ACC_CLR;
        w.wr     = WR_TORQUE;
        w.jmp    = JMP_ILOOP;
        w.target = PC_MHI;
      end
      PC_DONE: begin
        w.wr  = WR_OUT;
        w.jmp = JMP_END;
      end
      default: begin
        w.jmp = JMP_END;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* src/jptm_sequencer.sv */
// Microcode sequencer: step counter, joint and motor loop indexes, jumps.
// Depends on jptm_pkg for the program table and the control word types.
`timescale 1ns / 1ps
`default_nettype none

module jptm_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            out_free_i,
  output logic            busy_o,
  output jptm_pkg::ctl_t  ctl_o
);

  logic                         busy_q, busy_d;
  logic [jptm_pkg::PC_W-1:0]    pc_q, pc_d;
  logic [jptm_pkg::IDX_W-1:0]   j_q, j_d;
  logic [jptm_pkg::IDX_W-1:0]   i_q, i_d;
  jptm_pkg::uword_t             word;

  assign word   = jptm_pkg::ucode(pc_q);
  assign busy_o = busy_q;

  always_comb begin
    ctl_o.run = busy_q;
    ctl_o.j   = j_q;
    ctl_o.i   = i_q;
    if (busy_q) begin
      ctl_o.mul = word.mul;
      ctl_o.acc = word.acc;
      if (word.wr == jptm_pkg::WR_OUT && !out_free_i) begin
        ctl_o.wr = jptm_pkg::WR_NONE;
      end else begin
        ctl_o.wr = word.wr;
      end
    end else begin
      ctl_o.mul = jptm_pkg::MUL_NONE;
      ctl_o.acc = jptm_pkg::ACC_HOLD;
      ctl_o.wr  = jptm_pkg::WR_NONE;
    end
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    j_d    = j_q;
    i_d    = i_q;
    if (start_i) begin
      busy_d = 1'b1;
      pc_d   = '0;
      j_d    = '0;
      i_d    = '0;
    end else if (busy_q) begin
      case (word.jmp)
        jptm_pkg::JMP_NEXT: begin
          pc_d = pc_q + jptm_pkg::PC_W'(1);
        end
        jptm_pkg::JMP_JLOOP: begin
          if (j_q != jptm_pkg::IDX_LAST) begin
            j_d  = j_q + jptm_pkg::IDX_W'(1);
            pc_d = word.target;
          end else begin
            j_d  = '0;
            pc_d = pc_q + jptm_pkg::PC_W'(1);
          end
        end
        jptm_pkg::JMP_ILOOP: begin
          if (i_q != jptm_pkg::IDX_LAST) begin
            i_d  = i_q + jptm_pkg::IDX_W'(1);
            pc_d = word.target;
          end else begin
            i_d  = '0;
            pc_d = pc_q + jptm_pkg::PC_W'(1);
          end
        end
        jptm_pkg::JMP_END: begin
          if (out_free_i) begin
            busy_d = 1'b0;
            pc_d   = '0;
          end
        end
        default: begin
          busy_d = 1'b0;
          pc_d   = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
      j_q    <= '0;
      i_q    <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
      j_q    <= j_d;
      i_q    <= i_d;
    end
  end

endmodule

`default_nettype wire

/* src/jptm_datapath.sv */
// Datapath: config registers, one shared 17x34 multiplier, accumulator, joint state.
// Depends on jptm_pkg; driven by the control word of jptm_sequencer.
`timescale 1ns / 1ps
`default_nettype none

module jptm_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  jptm_pkg::ctl_t                         ctl_i,
  input  logic                                   in_accept_i,
  input  logic signed [jptm_pkg::POS_W-1:0]      meas_i [jptm_pkg::JOINTS],
  input  logic signed [jptm_pkg::POS_W-1:0]      targ_i [jptm_pkg::JOINTS],
  input  logic                                   cfg_we_i,
  input  logic [jptm_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [jptm_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [jptm_pkg::TORQ_W-1:0]     torque_o [jptm_pkg::JOINTS]
);

  logic [jptm_pkg::CFG_DATA_W-1:0]           kp_q, kv_q;
  logic [jptm_pkg::IPER_W-1:0]               iper_q;
  logic [jptm_pkg::CFG_DATA_W-1:0]           col_q [jptm_pkg::JOINTS];

  logic signed [jptm_pkg::POS_W-1:0]         meas_q [jptm_pkg::JOINTS];
  logic signed [jptm_pkg::POS_W-1:0]         targ_q [jptm_pkg::JOINTS];
  logic signed [jptm_pkg::POS_W-1:0]         prev_q [jptm_pkg::JOINTS];
  logic                                      have_prev_q;

  logic signed [jptm_pkg::VEL_W-1:0]         vel_q;
  logic signed [jptm_pkg::FORCE_W-1:0]       force_q [jptm_pkg::JOINTS];
  logic signed [jptm_pkg::PROD_W-1:0]        prod_q;
  logic signed [jptm_pkg::ACC_W-1:0]         acc_q, acc_d;
  logic signed [jptm_pkg::TORQ_W-1:0]        torque_q [jptm_pkg::JOINTS];
  logic signed [jptm_pkg::TORQ_W-1:0]        out_q [jptm_pkg::JOINTS];
  logic                                      out_valid_q;

  logic signed [jptm_pkg::POS_W-1:0]         meas_j, targ_j, prev_j, coef;
  logic [jptm_pkg::GAIN_W-1:0]               kp_lane, kv_lane;
  logic signed [jptm_pkg::ERR_W-1:0]         err_j, delta_j;
  logic signed [jptm_pkg::FORCE_W-1:0]       force_j;
  logic signed [jptm_pkg::MUL_A_W-1:0]       mul_a;
  logic signed [jptm_pkg::MUL_B_W-1:0]       mul_b;
  logic signed [jptm_pkg::PROD_W-1:0]        mul_p;
  logic signed [jptm_pkg::ACC_W-1:0]         prod_ext, diff, acc_sh;
  logic signed [jptm_pkg::TORQ_W-1:0]        torque_sat;

  assign meas_j  = meas_q[ctl_i.j];
  assign targ_j  = targ_q[ctl_i.j];
  assign prev_j  = prev_q[ctl_i.j];
  assign force_j = force_q[ctl_i.j];
  assign kp_lane = kp_q[jptm_pkg::GAIN_W*ctl_i.j +: jptm_pkg::GAIN_W];
  assign kv_lane = kv_q[jptm_pkg::GAIN_W*ctl_i.j +: jptm_pkg::GAIN_W];
  assign coef    = $signed(col_q[ctl_i.i][jptm_pkg::GAIN_W*ctl_i.j +: jptm_pkg::GAIN_W]);

  assign err_j   = jptm_pkg::ERR_W'(targ_j) - jptm_pkg::ERR_W'(meas_j);
  assign delta_j = have_prev_q ? (jptm_pkg::ERR_W'(meas_j) - jptm_pkg::ERR_W'(prev_j)) : '0;

  always_comb begin
    case (ctl_i.mul)
      jptm_pkg::MUL_DIP: begin
        mul_a = delta_j;
        mul_b = $signed({{(jptm_pkg::MUL_B_W-jptm_pkg::IPER_W){1'b0}}, iper_q});
      end
      jptm_pkg::MUL_KPE: begin
        mul_a = $signed({1'b0, kp_lane});
        mul_b = jptm_pkg::MUL_B_W'(err_j);
      end
      jptm_pkg::MUL_KVV: begin
        mul_a = $signed({1'b0, kv_lane});
        mul_b = jptm_pkg::MUL_B_W'(vel_q);
      end
      jptm_pkg::MUL_CFH: begin
        mul_a = jptm_pkg::MUL_A_W'(coef);
        mul_b = jptm_pkg::MUL_B_W'(
                  $signed(force_j[jptm_pkg::FORCE_W-1:jptm_pkg::FORCE_LO_W]));
      end
      jptm_pkg::MUL_CFL: begin
        mul_a = jptm_pkg::MUL_A_W'(coef);
        mul_b = $signed({{(jptm_pkg::MUL_B_W-jptm_pkg::FORCE_LO_W){1'b0}},
                         force_j[jptm_pkg::FORCE_LO_W-1:0]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = jptm_pkg::ACC_W'(prod_q);
  assign diff     = acc_q - prod_ext;
  assign acc_sh   = acc_q >>> jptm_pkg::TORQ_SHIFT;

  always_comb begin
    if (acc_sh > jptm_pkg::SAT_HI) begin
      torque_sat = jptm_pkg::TORQ_W'(jptm_pkg::SAT_HI);
    end else if (acc_sh < jptm_pkg::SAT_LO) begin
      torque_sat = jptm_pkg::TORQ_W'(jptm_pkg::SAT_LO);
    end else begin
      torque_sat = acc_sh[jptm_pkg::TORQ_W-1:0];
    end
  end

  always_comb begin
    case (ctl_i.acc)
      jptm_pkg::ACC_CLR:    acc_d = '0;
      jptm_pkg::ACC_LOAD:   acc_d = prod_ext;
      jptm_pkg::ACC_ADD:    acc_d = acc_q + prod_ext;
      jptm_pkg::ACC_ADD_HI: acc_d = acc_q + (prod_ext <<< jptm_pkg::FORCE_LO_W);
      default:              acc_d = acc_q;
    endcase
  end

  // config registers and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q        <= jptm_pkg::KP_RESET;
      kv_q        <= jptm_pkg::KV_RESET;
      iper_q      <= jptm_pkg::IPER_RESET;
      col_q       <= '{default: '0};
      prev_q      <= '{default: '0};
      have_prev_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          jptm_pkg::CFG_KP:   kp_q     <= cfg_data_i;
          jptm_pkg::CFG_KV:   kv_q     <= cfg_data_i;
          jptm_pkg::CFG_IPER: iper_q   <= cfg_data_i[jptm_pkg::IPER_W-1:0];
          jptm_pkg::CFG_COL0: col_q[0] <= cfg_data_i;
          jptm_pkg::CFG_COL1: col_q[1] <= cfg_data_i;
          jptm_pkg::CFG_COL2: col_q[2] <= cfg_data_i;
          jptm_pkg::CFG_COL3: col_q[3] <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (ctl_i.wr == jptm_pkg::WR_FORCE) begin
        prev_q[ctl_i.j] <= meas_j;
      end
      if (ctl_i.wr == jptm_pkg::WR_OUT) begin
        have_prev_q <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      meas_q <= meas_i;
      targ_q <= targ_i;
    end
    prod_q <= mul_p;
    acc_q  <= acc_d;
    case (ctl_i.wr)
      jptm_pkg::WR_VEL: begin
        vel_q <= $signed(prod_q[jptm_pkg::VEL_SHIFT +: jptm_pkg::VEL_W]);
      end
      jptm_pkg::WR_FORCE: begin
        force_q[ctl_i.j] <= $signed(diff[jptm_pkg::FORCE_SHIFT +: jptm_pkg::FORCE_W]);
      end
      jptm_pkg::WR_TORQUE: begin
        torque_q[ctl_i.i] <= torque_sat;
      end
      jptm_pkg::WR_OUT: begin
        out_q <= torque_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign torque_o    = out_q;

endmodule

`default_nettype wire

/* src/joint_pd_torque_mapper.sv */
// Joint PD controller with transposed transmission mapping; top level.
// Uses jptm_pkg, jptm_sequencer, jptm_datapath and the assertion macro header.
// Each request runs a microcode program on one shared 17x34 multiplier:
// 4 steps per joint, 10 per motor, plus clear and output steps. The output step waits until
// the previous result has been taken; a new request is taken only while the sequencer is idle.
// Reset (async, active low): sequencer idle, no result, previous positions zero, config defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "joint_pd_torque_mapper_macros.svh"

module joint_pd_torque_mapper (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [jptm_pkg::POS_W-1:0]   measured_pos_0_i,
  input  logic signed [jptm_pkg::POS_W-1:0]   measured_pos_1_i,
  input  logic signed [jptm_pkg::POS_W-1:0]   measured_pos_2_i,
  input  logic signed [jptm_pkg::POS_W-1:0]   measured_pos_3_i,
  input  logic signed [jptm_pkg::POS_W-1:0]   target_pos_0_i,
  input  logic signed [jptm_pkg::POS_W-1:0]   target_pos_1_i,
  input  logic signed [jptm_pkg::POS_W-1:0]   target_pos_2_i,
  input  logic signed [jptm_pkg::POS_W-1:0]   target_pos_3_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [jptm_pkg::TORQ_W-1:0]  motor_torque_0_o,
  output logic signed [jptm_pkg::TORQ_W-1:0]  motor_torque_1_o,
  output logic signed [jptm_pkg::TORQ_W-1:0]  motor_torque_2_o,
  output logic signed [jptm_pkg::TORQ_W-1:0]  motor_torque_3_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [jptm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [jptm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic                                 busy;
  logic                                 in_accept;
  logic                                 out_free;
  jptm_pkg::ctl_t                       ctl;
  logic signed [jptm_pkg::POS_W-1:0]    meas [jptm_pkg::JOINTS];
  logic signed [jptm_pkg::POS_W-1:0]    targ [jptm_pkg::JOINTS];
  logic signed [jptm_pkg::TORQ_W-1:0]   torque [jptm_pkg::JOINTS];

  assign in_ready_o  = !busy;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_o || out_ready_i;
  assign cfg_ready_o = 1'b1;

  assign meas[0] = measured_pos_0_i;
  assign meas[1] = measured_pos_1_i;
  assign meas[2] = measured_pos_2_i;
  assign meas[3] = measured_pos_3_i;
  assign targ[0] = target_pos_0_i;
  assign targ[1] = target_pos_1_i;
  assign targ[2] = target_pos_2_i;
  assign targ[3] = target_pos_3_i;

  assign motor_torque_0_o = torque[0];
  assign motor_torque_1_o = torque[1];
  assign motor_torque_2_o = torque[2];
  assign motor_torque_3_o = torque[3];

  jptm_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctl_o      (ctl)
  );

  jptm_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .in_accept_i (in_accept),
    .meas_i      (meas),
    .targ_i      (targ),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .torque_o    (torque)
  );

  `JPTM_ASSERT(a_accept_busy, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o)
  `JPTM_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, ctl.wr == jptm_pkg::WR_OUT && out_valid_o && !out_ready_i)
  `JPTM_ASSERT(a_done_has_result, clk_i, rst_ni, $fell(ctl.run) |-> out_valid_o)

endmodule

`default_nettype wire
